// File: design/assert_macros.svh
// Assertion helpers shared by the design files. Each expects clk and rst_n
// in scope and is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Whenever ante holds, cons holds at the same edge.
`define ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever ante holds, cons holds at the following edge.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/eet_pkg.sv
package eet_pkg;

  localparam int FRAC_BITS   = 30;
  localparam int COORD_WIDTH = 36;
  localparam int TRIG_WIDTH  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH;

  // Coefficient: trig value or rounded product of two trig values.
  localparam int COEF_W = 2 * TRIG_WIDTH - FRAC_BITS;
  // Operand: a coordinate or a coordinate minus the origin.
  localparam int VAL_W  = COORD_WIDTH + 1;
  localparam int LO_W   = VAL_W / 2;
  localparam int HI_W   = VAL_W - LO_W;
  localparam int PP_W   = COEF_W + HI_W + 1;
  localparam int PROD_W = COEF_W + VAL_W;
  localparam int TERM_W = PROD_W - FRAC_BITS + 1;
  localparam int SUM_W  = TERM_W + 2;
  localparam int KP_W   = 2 * TRIG_WIDTH + 1;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE =
    $signed(TRIG_WIDTH'(1) << FRAC_BITS);
  localparam logic signed [COORD_WIDTH-1:0] RES_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] RES_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_LAT   = CFG_IDX_W'(0),
    REG_COS_LAT   = CFG_IDX_W'(1),
    REG_SIN_LON   = CFG_IDX_W'(2),
    REG_COS_LON   = CFG_IDX_W'(3),
    REG_ORIGIN_EX = CFG_IDX_W'(4),
    REG_ORIGIN_EY = CFG_IDX_W'(5),
    REG_ORIGIN_EZ = CFG_IDX_W'(6)
  } cfg_reg_t;

  typedef enum logic {
    OP_TO_LOCAL = 1'b0,
    OP_TO_ECEF  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    CS_ZERO,
    CS_SLAT,
    CS_CLAT,
    CS_SLON,
    CS_CLON,
    CS_K_SLCL,
    CS_K_SLSL,
    CS_K_CLCL,
    CS_K_CLSL
  } coef_sel_t;

  typedef struct packed {
    coef_sel_t sel;
    logic      neg;
  } term_ctl_t;

  typedef struct packed {
    logic                          operation;
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
    logic signed [COORD_WIDTH-1:0] coord_c;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] res_a;
    logic signed [COORD_WIDTH-1:0] res_b;
    logic signed [COORD_WIDTH-1:0] res_c;
    logic                          saturated;
  } out_item_t;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] v_a;
    logic signed [VAL_W-1:0] v_b;
    logic signed [VAL_W-1:0] v_c;
  } q_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]      slat;
    logic signed [COEF_W-1:0]      clat;
    logic signed [COEF_W-1:0]      slon;
    logic signed [COEF_W-1:0]      clon;
    logic signed [COEF_W-1:0]      k_slcl;
    logic signed [COEF_W-1:0]      k_slsl;
    logic signed [COEF_W-1:0]      k_clcl;
    logic signed [COEF_W-1:0]      k_clsl;
    logic signed [COORD_WIDTH-1:0] ox;
    logic signed [COORD_WIDTH-1:0] oy;
    logic signed [COORD_WIDTH-1:0] oz;
  } cfg_state_t;

  // Coefficient and sign of the term in a given result row and operand column.
  // The local-to-earth direction uses the transpose of the forward rotation.
  function automatic term_ctl_t term_ctl(logic op, logic [AXIS_W-1:0] row,
                                         logic [AXIS_W-1:0] col);
    term_ctl_t         t;
    logic [AXIS_W-1:0] r;
    logic [AXIS_W-1:0] c;
    r = (op == OP_TO_ECEF) ? col : row;
    c = (op == OP_TO_ECEF) ? row : col;
    unique case ({r, c})
      4'b00_00: t = '{sel: CS_SLON,   neg: 1'b1};
      4'b00_01: t = '{sel: CS_CLON,   neg: 1'b0};
      4'b01_00: t = '{sel: CS_K_SLCL, neg: 1'b1};
      4'b01_01: t = '{sel: CS_K_SLSL, neg: 1'b1};
      4'b01_10: t = '{sel: CS_CLAT,   neg: 1'b0};
      4'b10_00: t = '{sel: CS_K_CLCL, neg: 1'b0};
      4'b10_01: t = '{sel: CS_K_CLSL, neg: 1'b0};
      4'b10_10: t = '{sel: CS_SLAT,   neg: 1'b0};
      default:  t = '{sel: CS_ZERO,   neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

// File: design/eet_coef.sv
module eet_coef
  import eet_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_state_t            cfg
);

  logic signed [TRIG_WIDTH-1:0]  sin_lat_r, cos_lat_r, sin_lon_r, cos_lon_r;
  logic signed [COORD_WIDTH-1:0] ox_r, oy_r, oz_r;
  logic signed [COEF_W-1:0]      k_slcl_r, k_slsl_r, k_clcl_r, k_clsl_r;

  // Product of two trig values rounded to FRAC_BITS, ties away from zero.
  function automatic logic signed [COEF_W-1:0] trig_mul(
    logic signed [TRIG_WIDTH-1:0] x, logic signed [TRIG_WIDTH-1:0] y);
    logic signed [KP_W-1:0] p;
    logic signed [KP_W-1:0] half;
    logic signed [KP_W-1:0] negb;
    logic signed [KP_W-1:0] r;
    p    = x * y;
    half = $signed(KP_W'(1) << (FRAC_BITS - 1));
    negb = $signed(KP_W'(p[KP_W-1]));
    r    = (p + half - negb) >>> FRAC_BITS;
    return COEF_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_lat_r <= '0;
      cos_lat_r <= TRIG_ONE;
      sin_lon_r <= '0;
      cos_lon_r <= TRIG_ONE;
      ox_r      <= '0;
      oy_r      <= '0;
      oz_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIN_LAT:   sin_lat_r <= cfg_wdata[TRIG_WIDTH-1:0];
        REG_COS_LAT:   cos_lat_r <= cfg_wdata[TRIG_WIDTH-1:0];
        REG_SIN_LON:   sin_lon_r <= cfg_wdata[TRIG_WIDTH-1:0];
        REG_COS_LON:   cos_lon_r <= cfg_wdata[TRIG_WIDTH-1:0];
        REG_ORIGIN_EX: ox_r      <= cfg_wdata[COORD_WIDTH-1:0];
        REG_ORIGIN_EY: oy_r      <= cfg_wdata[COORD_WIDTH-1:0];
        REG_ORIGIN_EZ: oz_r      <= cfg_wdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The combined coefficients follow the trig registers in the next cycle,
  // well before an item accepted after a write reaches the multipliers.
  always_ff @(posedge clk) begin
    k_slcl_r <= trig_mul(sin_lat_r, cos_lon_r);
    k_slsl_r <= trig_mul(sin_lat_r, sin_lon_r);
    k_clcl_r <= trig_mul(cos_lat_r, cos_lon_r);
    k_clsl_r <= trig_mul(cos_lat_r, sin_lon_r);
  end

  always_comb begin
    cfg.slat   = COEF_W'(sin_lat_r);
    cfg.clat   = COEF_W'(cos_lat_r);
    cfg.slon   = COEF_W'(sin_lon_r);
    cfg.clon   = COEF_W'(cos_lon_r);
    cfg.k_slcl = k_slcl_r;
    cfg.k_slsl = k_slsl_r;
    cfg.k_clcl = k_clcl_r;
    cfg.k_clsl = k_clsl_r;
    cfg.ox     = ox_r;
    cfg.oy     = oy_r;
    cfg.oz     = oz_r;
  end

endmodule

// File: design/eet_front.sv
module eet_front
  import eet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  cfg_state_t cfg,
  output logic       q_wr,
  output q_item_t    q_wdata,
  input  logic       q_full
);

  `include "assert_macros.svh"

  logic     f_valid_r, f_valid_nxt;
  in_item_t f_item_r;
  logic     accept;

  logic signed [VAL_W-1:0] a_ext, b_ext, c_ext;

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_wr     = f_valid_r && !q_full;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_wr) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= in_data;
    end
  end

  // Forward items are moved to the origin here; reverse items pass as they are.
  always_comb begin
    a_ext = VAL_W'(f_item_r.coord_a);
    b_ext = VAL_W'(f_item_r.coord_b);
    c_ext = VAL_W'(f_item_r.coord_c);
    q_wdata.operation = f_item_r.operation;
    if (f_item_r.operation == OP_TO_ECEF) begin
      q_wdata.v_a = a_ext;
      q_wdata.v_b = b_ext;
      q_wdata.v_c = c_ext;
    end else begin
      q_wdata.v_a = a_ext - VAL_W'(cfg.ox);
      q_wdata.v_b = b_ext - VAL_W'(cfg.oy);
      q_wdata.v_c = c_ext - VAL_W'(cfg.oz);
    end
  end

  `ASSERT_NEXT(a_front_hold, f_valid_r && q_full, f_valid_r && $stable(f_item_r))

endmodule

// File: design/eet_queue.sv
module eet_queue
  import eet_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  q_item_t wdata,
  output logic    full,
  input  logic    rd,
  output q_item_t rdata,
  output logic    empty
);

  `include "assert_macros.svh"

  q_item_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_count_rise, wr && !rd, count_r == $past(count_r) + 1'b1)

endmodule

// File: design/eet_back.sv
module eet_back
  import eet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  q_item_t    q_rdata,
  output logic       q_rd,
  input  cfg_state_t cfg,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  `include "assert_macros.svh"

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(RES_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(RES_MIN);
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    $signed(PROD_W'(1) << (FRAC_BITS - 1));

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic ready1, ready2, ready3, ready4, ready5;
  logic ld2, ld3, ld4, ld5;
  logic op1_r, op2_r, op3_r;

  logic signed [VAL_W-1:0]       vals [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] orig [NUM_AXES];

  logic signed [PP_W-1:0]   pp_lo_r [NUM_AXES][NUM_AXES];
  logic signed [PP_W-1:0]   pp_hi_r [NUM_AXES][NUM_AXES];
  logic                     neg1_r  [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] prod_r  [NUM_AXES][NUM_AXES];
  logic                     neg2_r  [NUM_AXES][NUM_AXES];
  logic signed [TERM_W-1:0] term_r  [NUM_AXES][NUM_AXES];
  logic signed [SUM_W-1:0]  sum_r   [NUM_AXES];

  logic signed [COORD_WIDTH-1:0] res_nxt [NUM_AXES];
  logic                          sat_nxt [NUM_AXES];
  out_item_t                     out_r;

  // Each stage moves when it is empty or the stage after it moves.
  assign ready5 = !out_valid_r || !out_stall;
  assign ready4 = !v4_r || ready5;
  assign ready3 = !v3_r || ready4;
  assign ready2 = !v2_r || ready3;
  assign ready1 = !v1_r || ready2;
  assign q_rd   = !q_empty && ready1;
  assign ld2    = v1_r && ready2;
  assign ld3    = v2_r && ready3;
  assign ld4    = v3_r && ready4;
  assign ld5    = v4_r && ready5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= q_rd;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
      if (ready5) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) op1_r <= q_rdata.operation;
    if (ld2)  op2_r <= op1_r;
    if (ld3)  op3_r <= op2_r;
  end

  assign vals[0] = q_rdata.v_a;
  assign vals[1] = q_rdata.v_b;
  assign vals[2] = q_rdata.v_c;
  assign orig[0] = cfg.ox;
  assign orig[1] = cfg.oy;
  assign orig[2] = cfg.oz;

  function automatic logic signed [COEF_W-1:0] pick_coef(coef_sel_t s, cfg_state_t k);
    logic signed [COEF_W-1:0] c;
    unique case (s)
      CS_SLAT:   c = k.slat;
      CS_CLAT:   c = k.clat;
      CS_SLON:   c = k.slon;
      CS_CLON:   c = k.clon;
      CS_K_SLCL: c = k.k_slcl;
      CS_K_SLSL: c = k.k_slsl;
      CS_K_CLCL: c = k.k_clcl;
      CS_K_CLSL: c = k.k_clsl;
      default:   c = '0;
    endcase
    return c;
  endfunction

  for (genvar gr = 0; gr < NUM_AXES; gr++) begin : g_row
    for (genvar gc = 0; gc < NUM_AXES; gc++) begin : g_col
      term_ctl_t                  ctl;
      logic signed [COEF_W-1:0]   coef;
      logic signed [LO_W:0]       lo;
      logic signed [HI_W-1:0]     hi;
      logic signed [COEF_W+LO_W:0]   plo;
      logic signed [COEF_W+HI_W-1:0] phi;
      logic signed [PROD_W-1:0]   negb;
      logic signed [PROD_W-1:0]   rnd;
      logic signed [TERM_W-1:0]   mag;

      // Stage 1: the operand is split in two halves, each multiplied by the
      // coefficient.
      always_comb begin
        ctl  = term_ctl(q_rdata.operation, AXIS_W'(gr), AXIS_W'(gc));
        coef = pick_coef(ctl.sel, cfg);
        lo   = $signed({1'b0, vals[gc][LO_W-1:0]});
        hi   = vals[gc][VAL_W-1:LO_W];
        plo  = coef * lo;
        phi  = coef * hi;
      end

      always_ff @(posedge clk) begin
        if (q_rd) begin
          pp_lo_r[gr][gc] <= PP_W'(plo);
          pp_hi_r[gr][gc] <= PP_W'(phi);
          neg1_r[gr][gc]  <= ctl.neg;
        end
      end

      // Stage 2: full product.
      always_ff @(posedge clk) begin
        if (ld2) begin
          prod_r[gr][gc] <= (PROD_W'(pp_hi_r[gr][gc]) <<< LO_W) + PROD_W'(pp_lo_r[gr][gc]);
          neg2_r[gr][gc] <= neg1_r[gr][gc];
        end
      end

      // Stage 3: round to nearest with ties away from zero, then apply the
      // rotation's sign.
      always_comb begin
        negb = $signed(PROD_W'(prod_r[gr][gc][PROD_W-1]));
        rnd  = (prod_r[gr][gc] + ROUND_HALF - negb) >>> FRAC_BITS;
        mag  = TERM_W'(rnd);
      end

      always_ff @(posedge clk) begin
        if (ld3) begin
          term_r[gr][gc] <= neg2_r[gr][gc] ? -mag : mag;
        end
      end
    end

    // Stage 4: row sum, with the origin added in the reverse direction.
    always_ff @(posedge clk) begin
      if (ld4) begin
        sum_r[gr] <= SUM_W'(term_r[gr][0]) + SUM_W'(term_r[gr][1]) + SUM_W'(term_r[gr][2])
                     + ((op3_r == OP_TO_ECEF) ? SUM_W'(orig[gr]) : SUM_W'(0));
      end
    end

    always_comb begin
      res_nxt[gr] = COORD_WIDTH'(sum_r[gr]);
      sat_nxt[gr] = 1'b0;
      if (sum_r[gr] > SUM_MAX) begin
        res_nxt[gr] = RES_MAX;
        sat_nxt[gr] = 1'b1;
      end else if (sum_r[gr] < SUM_MIN) begin
        res_nxt[gr] = RES_MIN;
        sat_nxt[gr] = 1'b1;
      end
    end
  end

  // Stage 5: clipped result held until the receiver takes it.
  always_ff @(posedge clk) begin
    if (ld5) begin
      out_r.res_a     <= res_nxt[0];
      out_r.res_b     <= res_nxt[1];
      out_r.res_c     <= res_nxt[2];
      out_r.saturated <= sat_nxt[0] || sat_nxt[1] || sat_nxt[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPLY(a_sat_extreme, out_valid_r && out_r.saturated, out_r.res_a == RES_MAX || out_r.res_a == RES_MIN || out_r.res_b == RES_MAX || out_r.res_b == RES_MIN || out_r.res_c == RES_MAX || out_r.res_c == RES_MIN)

endmodule

// File: design/ecef_enu_transform.sv
// Earth-centred to local east/north/up conversion and back.
// Input channel (in_valid, in_stall, in_data): one point per transfer; the
// operation bit selects earth-centred to local (0) or local to earth-centred (1).
// Result channel (out_valid, out_stall, out_data): one result per input point,
// in order, with a flag set when any component was clipped to the coordinate range.
// Configuration (cfg_we, cfg_idx, cfg_wdata): sines and cosines of the origin
// latitude and longitude and the origin position, written while no point is
// in flight. Products of trig pairs are refreshed in the cycle after a write.
// A point passes from input transfer to result valid through the input register,
// queue, partial products, product sum, rounding, row sum, then the clipped output
// register. One point per cycle is sustained while out_stall is low; the pipeline
// is set by the nine 34 x 19 bit partial-product multipliers per half-operand.
// A stalled result is held in the output register while the stages behind it
// fill; a four-entry queue separates input acceptance from the arithmetic, and
// in_stall rises only when both the queue and the input register are full.
// Synchronous reset empties the pipeline and queue and restores the unit
// rotation (cosines one, sines zero) with the origin at zero.
module ecef_enu_transform
  import eet_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_state_t cfg;
  logic       q_wr, q_full, q_rd, q_empty;
  q_item_t    q_wdata, q_rdata;

  eet_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  eet_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  eet_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  eet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import eet_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = CFG_IDX_W'(7);
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 170;
  localparam logic [127:0] TERM_CAP = 128'd1 << 60;
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = RES_MAX;
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = RES_MIN;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_output    = 1'b0;

  // Local copy of the register file used for prediction.
  logic signed [TRIG_WIDTH-1:0]  m_sin_lat;
  logic signed [TRIG_WIDTH-1:0]  m_cos_lat;
  logic signed [TRIG_WIDTH-1:0]  m_sin_lon;
  logic signed [TRIG_WIDTH-1:0]  m_cos_lon;
  logic signed [COORD_WIDTH-1:0] m_org_x;
  logic signed [COORD_WIDTH-1:0] m_org_y;
  logic signed [COORD_WIDTH-1:0] m_org_z;

  out_item_t pending_results[$];

  int error_count     = 0;
  int results_checked = 0;
  int saturated_seen  = 0;
  int items_sent      = 0;
  int local_items     = 0;
  int ecef_items      = 0;
  int settings_count  = 0;

  ecef_enu_transform u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_data.saturated) saturated_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected result: a=%0d b=%0d c=%0d sat=%0b",
                   out_data.res_a, out_data.res_b, out_data.res_c, out_data.saturated);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.res_a !== want.res_a || out_data.res_b !== want.res_b ||
            out_data.res_c !== want.res_c || out_data.saturated !== want.saturated) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch: expected a=%0d b=%0d c=%0d sat=%0b, got a=%0d b=%0d c=%0d sat=%0b",
                     want.res_a, want.res_b, want.res_c, want.saturated,
                     out_data.res_a, out_data.res_b, out_data.res_c, out_data.saturated);
          end
        end
      end
    end
  end

  // Rounded fixed-point product, ties away from zero, magnitude capped at 2^60.
  function automatic longint round_term(input longint coef, input longint val);
    logic [63:0]  mc;
    logic [63:0]  mv;
    logic [127:0] q;
    mc = (coef < 0) ? -coef : coef;
    mv = (val < 0) ? -val : val;
    q  = ({64'd0, mc} * {64'd0, mv} + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (q > TERM_CAP) q = TERM_CAP;
    return ((coef < 0) != (val < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clip_coord(input longint v,
                                                              inout logic sat);
    if (v > longint'(RES_MAX)) begin
      sat = 1'b1;
      return RES_MAX;
    end
    if (v < longint'(RES_MIN)) begin
      sat = 1'b1;
      return RES_MIN;
    end
    return COORD_WIDTH'(v);
  endfunction

  function automatic out_item_t predict_result(input in_item_t p);
    longint    slat, clat, slon, clon;
    longint    k_slcl, k_slsl, k_clcl, k_clsl;
    longint    ox, oy, oz, a, b, c, dx, dy, dz;
    longint    s0, s1, s2;
    logic      sat;
    out_item_t r;
    slat   = m_sin_lat;
    clat   = m_cos_lat;
    slon   = m_sin_lon;
    clon   = m_cos_lon;
    ox     = m_org_x;
    oy     = m_org_y;
    oz     = m_org_z;
    a      = p.coord_a;
    b      = p.coord_b;
    c      = p.coord_c;
    k_slcl = round_term(slat, clon);
    k_slsl = round_term(slat, slon);
    k_clcl = round_term(clat, clon);
    k_clsl = round_term(clat, slon);
    if (p.operation == OP_TO_LOCAL) begin
      dx = a - ox;
      dy = b - oy;
      dz = c - oz;
      s0 = -round_term(slon, dx) + round_term(clon, dy);
      s1 = -round_term(k_slcl, dx) - round_term(k_slsl, dy) + round_term(clat, dz);
      s2 = round_term(k_clcl, dx) + round_term(k_clsl, dy) + round_term(slat, dz);
    end else begin
      s0 = ox - round_term(slon, a) - round_term(k_slcl, b) + round_term(k_clcl, c);
      s1 = oy + round_term(clon, a) - round_term(k_slsl, b) + round_term(k_clsl, c);
      s2 = oz + round_term(clat, b) + round_term(slat, c);
    end
    sat         = 1'b0;
    r.res_a     = clip_coord(s0, sat);
    r.res_b     = clip_coord(s1, sat);
    r.res_c     = clip_coord(s2, sat);
    r.saturated = sat;
    return r;
  endfunction

  // Signed random value spanning +/- 2^(bits-1).
  function automatic longint rand_span(input int bits);
    longint r;
    r = {$urandom, $urandom};
    return r >>> (64 - bits);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_trig_word();
    logic [TRIG_WIDTH-1:0] t;
    // Mostly normalized values; now and then any 32-bit pattern.
    if ($urandom_range(7) == 0) begin
      t = $urandom;
    end else begin
      t = TRIG_WIDTH'(longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824);
    end
    return {(CFG_DATA_W - TRIG_WIDTH)'($urandom), t};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_origin_word();
    if ($urandom_range(3) == 0) return CFG_DATA_W'({$urandom, $urandom});
    return CFG_DATA_W'(rand_span(34));
  endfunction

  function automatic in_item_t make_point(input op_t op,
                                          input logic signed [COORD_WIDTH-1:0] a,
                                          input logic signed [COORD_WIDTH-1:0] b,
                                          input logic signed [COORD_WIDTH-1:0] c);
    in_item_t p;
    p.operation = op;
    p.coord_a   = a;
    p.coord_b   = b;
    p.coord_c   = c;
    return p;
  endfunction

  // Half the points lie near the origin, the rest at earth scale or anywhere.
  function automatic in_item_t rand_point();
    in_item_t p;
    int       kind;
    p.operation = 1'($urandom_range(1));
    kind        = $urandom_range(7);
    if (kind < 4) begin
      p.coord_a = COORD_WIDTH'(rand_span(22));
      p.coord_b = COORD_WIDTH'(rand_span(22));
      p.coord_c = COORD_WIDTH'(rand_span(22));
      if (p.operation == OP_TO_LOCAL) begin
        p.coord_a = p.coord_a + m_org_x;
        p.coord_b = p.coord_b + m_org_y;
        p.coord_c = p.coord_c + m_org_z;
      end
    end else if (kind < 6) begin
      p.coord_a = COORD_WIDTH'(rand_span(34));
      p.coord_b = COORD_WIDTH'(rand_span(34));
      p.coord_c = COORD_WIDTH'(rand_span(34));
    end else begin
      p.coord_a = COORD_WIDTH'({$urandom, $urandom});
      p.coord_b = COORD_WIDTH'({$urandom, $urandom});
      p.coord_c = COORD_WIDTH'({$urandom, $urandom});
    end
    return p;
  endfunction

  task automatic reset_model();
    m_sin_lat = '0;
    m_cos_lat = TRIG_ONE;
    m_sin_lon = '0;
    m_cos_lon = TRIG_ONE;
    m_org_x   = '0;
    m_org_y   = '0;
    m_org_z   = '0;
  endtask

  // Leaves cfg_we high; close_writes lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_SIN_LAT:   m_sin_lat = value[TRIG_WIDTH-1:0];
      REG_COS_LAT:   m_cos_lat = value[TRIG_WIDTH-1:0];
      REG_SIN_LON:   m_sin_lon = value[TRIG_WIDTH-1:0];
      REG_COS_LON:   m_cos_lon = value[TRIG_WIDTH-1:0];
      REG_ORIGIN_EX: m_org_x   = value[COORD_WIDTH-1:0];
      REG_ORIGIN_EY: m_org_y   = value[COORD_WIDTH-1:0];
      REG_ORIGIN_EZ: m_org_z   = value[COORD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  task automatic random_setting();
    write_reg(REG_SIN_LAT, rand_trig_word());
    write_reg(REG_COS_LAT, rand_trig_word());
    write_reg(REG_SIN_LON, rand_trig_word());
    write_reg(REG_COS_LON, rand_trig_word());
    write_reg(REG_ORIGIN_EX, rand_origin_word());
    write_reg(REG_ORIGIN_EY, rand_origin_word());
    write_reg(REG_ORIGIN_EZ, rand_origin_word());
    close_writes();
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic send_point(input in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(p));
    items_sent++;
    if (p.operation == OP_TO_LOCAL) local_items++;
    else ecef_items++;
  endtask

  // Waits for every outstanding result, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_identity_rotation();
    set_idling(0, 0);
    send_point(make_point(OP_TO_LOCAL, '0, '0, '0));
    send_point(make_point(OP_TO_ECEF, '0, '0, '0));
    send_point(make_point(OP_TO_LOCAL, C_MAX, C_MAX, C_MAX));
    send_point(make_point(OP_TO_LOCAL, C_MIN, C_MIN, C_MIN));
    send_point(make_point(OP_TO_ECEF, C_MAX, C_MIN, -1));
    send_point(make_point(OP_TO_ECEF, C_MIN, 1, C_MAX));
    drain();
  endtask

  task automatic test_rounding_ties();
    // A factor of one half turns odd coordinates into exact ties.
    write_reg(REG_SIN_LON, CFG_DATA_W'(TRIG_ONE >>> 1));
    write_reg(REG_SIN_LAT, CFG_DATA_W'(TRIG_ONE >>> 1));
    write_reg(REG_COS_LAT, CFG_DATA_W'(-(TRIG_ONE >>> 1)));
    close_writes();
    set_idling(0, 0);
    send_point(make_point(OP_TO_LOCAL, 1, 0, 1));
    send_point(make_point(OP_TO_LOCAL, -1, 0, -1));
    send_point(make_point(OP_TO_LOCAL, 3, 5, -3));
    send_point(make_point(OP_TO_ECEF, 1, -1, 3));
    send_point(make_point(OP_TO_ECEF, -3, 3, 1));
    drain();
  endtask

  task automatic test_unused_register();
    write_reg(REG_UNUSED_IDX, '1);
    close_writes();
    send_point(make_point(OP_TO_LOCAL, 1000, -2000, 3000));
    send_point(make_point(OP_TO_ECEF, -7, 8, 9));
    drain();
  endtask

  task automatic test_extreme_settings();
    // Full-scale trig words with junk in the unused upper data bits.
    write_reg(REG_SIN_LAT, {4'hF, 32'h8000_0000});
    write_reg(REG_COS_LAT, {4'h5, 32'h7FFF_FFFF});
    write_reg(REG_SIN_LON, {4'h0, 32'h7FFF_FFFF});
    write_reg(REG_COS_LON, {4'hA, 32'h8000_0000});
    write_reg(REG_ORIGIN_EX, RES_MAX);
    write_reg(REG_ORIGIN_EY, RES_MIN);
    write_reg(REG_ORIGIN_EZ, RES_MAX);
    close_writes();
    set_idling(7, 7);
    send_point(make_point(OP_TO_LOCAL, C_MIN, C_MAX, C_MIN));
    send_point(make_point(OP_TO_LOCAL, C_MAX, C_MIN, C_MAX));
    send_point(make_point(OP_TO_ECEF, C_MAX, C_MAX, C_MAX));
    send_point(make_point(OP_TO_ECEF, C_MIN, C_MIN, C_MIN));
    send_point(make_point(OP_TO_ECEF, '0, '0, '0));
    send_point(make_point(OP_TO_LOCAL, '0, '0, '0));
    drain();
    write_reg(REG_SIN_LAT, '0);
    write_reg(REG_COS_LAT, '0);
    write_reg(REG_SIN_LON, '0);
    write_reg(REG_COS_LON, '0);
    write_reg(REG_ORIGIN_EX, RES_MIN);
    write_reg(REG_ORIGIN_EY, '0);
    write_reg(REG_ORIGIN_EZ, '1);
    close_writes();
    send_point(make_point(OP_TO_ECEF, C_MAX, C_MIN, C_MAX));
    send_point(make_point(OP_TO_LOCAL, -1, 0, 1));
    send_point(make_point(OP_TO_LOCAL, C_MIN, C_MAX, '0));
    send_point(make_point(OP_TO_ECEF, C_MIN, C_MIN, C_MIN));
    drain();
  endtask

  // The receiver refuses results long enough for the block to fill and
  // push back on the sender.
  task automatic test_output_hold_off();
    random_setting();
    set_idling(0, 0);
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
      end
      begin
        repeat (40) send_point(rand_point());
      end
    join
    drain();
  endtask

  task automatic test_random_points();
    for (int phase = 0; phase < 8; phase++) begin
      random_setting();
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(69, 0);
        2: set_idling(0, 69);
        default: set_idling(7, 7);
      endcase
      repeat (PHASE_ITEMS) send_point(rand_point());
      drain();
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_rotation();
    test_rounding_ties();
    test_unused_register();
    test_extreme_settings();
    test_output_hold_off();
    test_random_points();
    $display("Sent %0d points (%0d to local, %0d to earth-centred) over %0d register settings.",
             items_sent, local_items, ecef_items, settings_count);
    $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
             results_checked, saturated_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/eet_pkg.sv
design/eet_coef.sv
design/eet_front.sv
design/eet_queue.sv
design/eet_back.sv
design/ecef_enu_transform.sv
verif/tb_top.sv
